// ===== sv/mngm_pkg.sv =====
// ----------------------------------------------------------------------------
// mngm_pkg: shared types and constants of the midi note to gate mapper
// note map geometry, message codes, register indexes and the velocity curve
// ----------------------------------------------------------------------------
package mngm_pkg;

    localparam int GATE_COUNT = 8;
    localparam int MAP_DEPTH  = 16;
    localparam int MAP_IDX_W  = $clog2(MAP_DEPTH);
    localparam int POS_W      = MAP_IDX_W + 1;
    localparam int BANK_W     = 8;

    localparam logic [7:0] NOTE_BASE = 8'd60;

    // status byte classes
    localparam logic [7:0] RT_MASK    = 8'hF8;
    localparam logic [7:0] NOTE_MASK  = 8'hE0;
    localparam logic [7:0] NOTE_CLASS = 8'h80;
    localparam logic [7:0] HI_MASK    = 8'hF0;
    localparam logic [7:0] CC_CLASS   = 8'hB0;
    localparam logic [7:0] LO_MASK    = 8'h0F;
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;

    // running status slot
    localparam logic [1:0] SLOT_NOTE = 2'd1;
    localparam logic [1:0] SLOT_VEL  = 2'd2;

    // register indexes
    localparam logic CFG_LEARN_ENABLE = 1'b0;
    localparam logic CFG_GATE_INVERT  = 1'b1;

    localparam logic [15:0] CODE_TOP  = 16'hFEF0;
    localparam logic [15:0] CODE_STEP = 16'h01C0;

    localparam logic [POS_W-1:0] LEARN_CLEAR_POS = POS_W'(9);

    typedef struct packed {
        logic [BANK_W-1:0] gate_hit;
        logic [BANK_W-1:0] vel_hit;
    } mngm_chain_t;

    // dac code for a velocity, zero for velocity zero
    function automatic logic [15:0] vel_code(input logic [6:0] vel);
        logic [6:0]  vel_gap;
        logic [15:0] prod;
        begin
            vel_gap = 7'd127 - vel;
            prod = 16'(16'(vel_gap) * CODE_STEP);
            if (vel == 7'd0)
                vel_code = 16'd0;
            else
                vel_code = (CODE_TOP - prod) & 16'hFFF0;
        end
    endfunction

endpackage

// ===== sv/mngm_cell.sv =====
// ----------------------------------------------------------------------------
// mngm_cell: one note map entry
// holds a learned note, matches it against the message note and adds its
// gate or velocity bit to the hit masks passed along the row
// ----------------------------------------------------------------------------
module mngm_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [mngm_pkg::MAP_IDX_W-1:0]  cell_idx,
    input  logic                            learn_wr,
    input  logic [mngm_pkg::MAP_IDX_W-1:0]  learn_idx,
    input  logic [7:0]                      note,
    input  mngm_pkg::mngm_chain_t           chain_in,
    output mngm_pkg::mngm_chain_t           chain_out
);

    logic [7:0] entry_reg;
    logic [7:0] entry_next;
    logic       hit;
    logic       is_gate;
    logic [mngm_pkg::BANK_W-1:0] bit_sel;

    always_comb
    begin
        entry_next = entry_reg;
        if (learn_wr && learn_idx == cell_idx)
            entry_next = note;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= mngm_pkg::NOTE_BASE + 8'(cell_idx);
        else
            entry_reg <= entry_next;
    end

    assign hit     = (entry_reg == note);
    assign is_gate = (32'(cell_idx) < mngm_pkg::GATE_COUNT);
    assign bit_sel = mngm_pkg::BANK_W'(1) << cell_idx[2:0];

    always_comb
    begin
        chain_out = chain_in;
        if (hit && is_gate)
            chain_out.gate_hit = chain_in.gate_hit | bit_sel;
        if (hit && !is_gate)
            chain_out.vel_hit = chain_in.vel_hit | bit_sel;
    end

endmodule

// ===== sv/midi_note_to_gate_mapper_top.sv =====
// ----------------------------------------------------------------------------
// midi_note_to_gate_mapper_top: midi note message parser driving gates
// running status parser, row of note map cells, learn logic and a two-deep
// output buffer so bytes keep flowing while a result waits
// ----------------------------------------------------------------------------
// result: registered on the transfer of the closing data byte
// throughput: one byte per cycle unless stalled; the row of map cells matches
//   every entry in the same cycle, so one message completes per byte pair
// input stalls only while both output buffer entries are full
// reset: map holds notes 60..75, channel 9, gates off, learn off, no status
// ----------------------------------------------------------------------------
module midi_note_to_gate_mapper_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    // byte input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  gate_pins,
    output logic [7:0]  dac_write_mask,
    output logic [15:0] dac_code,
    output logic [4:0]  learn_position,
    output logic [3:0]  listen_channel
);

    localparam int IW = mngm_pkg::MAP_IDX_W;
    localparam int PW = mngm_pkg::POS_W;

    typedef struct packed {
        logic [7:0]  gate_pins;
        logic [7:0]  dac_write_mask;
        logic [15:0] dac_code;
        logic [4:0]  learn_position;
        logic [3:0]  listen_channel;
    } result_t;

    // configuration registers
    logic learn_en_reg;
    logic invert_reg;

    // parser and mapper state
    logic [7:0]    status_reg,  status_next;
    logic [7:0]    note_reg,    note_next;
    logic [1:0]    slot_reg,    slot_next;
    logic          accept_reg,  accept_next;
    logic [3:0]    chan_reg,    chan_next;
    logic [PW-1:0] pos_reg,     pos_next;
    logic [7:0]    gates_reg,   gates_next;

    // output buffer
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;

    logic        in_xfer;
    logic        out_xfer;
    logic        res_valid;
    result_t     res;
    logic        learn_wr;
    logic        learning;
    logic        is_on_msg;
    logic        is_off_msg;
    logic        note_on;
    logic [3:0]  msg_chan;
    logic [3:0]  learn_chan;
    logic [6:0]  vel;
    logic [mngm_pkg::BANK_W-1:0] gate_bit;
    logic [7:0]  mask;
    logic [15:0] code;

    mngm_pkg::mngm_chain_t chain [mngm_pkg::MAP_DEPTH+1];

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    // row of map cells; hit masks ripple from cell 0 to the last cell
    assign chain[0] = '0;

    for (genvar g = 0; g < mngm_pkg::MAP_DEPTH; g++)
    begin : g_cell
        mngm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (IW'(g)),
            .learn_wr  (learn_wr),
            .learn_idx (pos_reg[IW-1:0]),
            .note      (note_reg),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1])
        );
    end

    assign msg_chan   = status_reg[3:0];
    assign vel        = rx_byte[6:0];
    assign is_on_msg  = (status_reg[7:4] == mngm_pkg::NIB_NOTE_ON);
    assign is_off_msg = (status_reg[7:4] == mngm_pkg::NIB_NOTE_OFF);
    assign learning   = learn_en_reg && !pos_reg[PW-1];
    assign note_on    = status_reg[4] && (vel != 7'd0);
    // first learned note-on may adopt its own channel
    assign learn_chan = (pos_reg == '0) ? msg_chan : chan_reg;
    assign gate_bit   = mngm_pkg::BANK_W'(1) << pos_reg[2:0];

    // parser, learn and gate update
    always_comb
    begin
        status_next = status_reg;
        note_next   = note_reg;
        slot_next   = slot_reg;
        accept_next = accept_reg;
        chan_next   = chan_reg;
        pos_next    = pos_reg;
        gates_next  = gates_reg;
        learn_wr    = 1'b0;
        res_valid   = 1'b0;
        mask        = '0;
        code        = '0;

        if (in_xfer)
        begin
            if (rx_byte[7])
            begin
                // real-time bytes leave running status alone
                if ((rx_byte & mngm_pkg::RT_MASK) != mngm_pkg::RT_MASK)
                    accept_next = 1'b0;
                if ((rx_byte & mngm_pkg::NOTE_MASK) == mngm_pkg::NOTE_CLASS ||
                    (rx_byte & mngm_pkg::HI_MASK) == mngm_pkg::CC_CLASS)
                begin
                    status_next = rx_byte;
                    slot_next   = mngm_pkg::SLOT_NOTE;
                    accept_next = 1'b1;
                end
            end
            else if (accept_reg)
            begin
                if (slot_reg != mngm_pkg::SLOT_VEL)
                begin
                    note_next = rx_byte;
                    slot_next = mngm_pkg::SLOT_VEL;
                end
                else
                begin
                    // message complete
                    slot_next = mngm_pkg::SLOT_NOTE;
                    res_valid = 1'b1;

                    if (learning && is_on_msg)
                    begin
                        chan_next = learn_chan;
                        if (msg_chan == learn_chan && vel != 7'd0)
                        begin
                            learn_wr   = 1'b1;
                            gates_next = gates_reg | gate_bit;
                            pos_next   = pos_reg + PW'(1);
                            // ninth learned note drops the preview gates but gate 0
                            if (pos_next == mngm_pkg::LEARN_CLEAR_POS)
                                gates_next = gates_next & 8'h01;
                        end
                    end

                    if (!learning && msg_chan == chan_reg && (is_on_msg || is_off_msg))
                    begin
                        if (note_on)
                            gates_next = gates_reg | chain[mngm_pkg::MAP_DEPTH].gate_hit;
                        else
                            gates_next = gates_reg & ~chain[mngm_pkg::MAP_DEPTH].gate_hit;
                        mask = chain[mngm_pkg::MAP_DEPTH].vel_hit;
                        if (mask != '0 && note_on)
                            code = mngm_pkg::vel_code(vel);
                    end
                end
            end
        end

        // the user must write config only while idle; the block does not enforce it
        if (cfg_we && cfg_index == mngm_pkg::CFG_LEARN_ENABLE && cfg_data)
            pos_next = '0;
    end

    assign res.gate_pins      = gates_next ^ {8{invert_reg}};
    assign res.dac_write_mask = mask;
    assign res.dac_code       = code;
    assign res.learn_position = 5'(pos_next);
    assign res.listen_channel = chan_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_en_reg <= 1'b0;
            invert_reg   <= 1'b0;
            status_reg   <= '0;
            note_reg     <= '0;
            slot_reg     <= '0;
            accept_reg   <= 1'b0;
            chan_reg     <= 4'd9;
            pos_reg      <= '0;
            gates_reg    <= '0;
        end
        else
        begin
            status_reg <= status_next;
            note_reg   <= note_next;
            slot_reg   <= slot_next;
            accept_reg <= accept_next;
            chan_reg   <= chan_next;
            pos_reg    <= pos_next;
            gates_reg  <= gates_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mngm_pkg::CFG_LEARN_ENABLE: learn_en_reg <= cfg_data;
                    mngm_pkg::CFG_GATE_INVERT:  invert_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // output register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_xfer)
                skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_xfer)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_xfer)
                out_reg <= skid_reg;
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_xfer)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign gate_pins      = out_reg.gate_pins;
    assign dac_write_mask = out_reg.dac_write_mask;
    assign dac_code       = out_reg.dac_code;
    assign learn_position = out_reg.learn_position;
    assign listen_channel = out_reg.listen_channel;

    // the skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("skid entry full with empty output register");

    // a dac code only goes out with a velocity channel selected
    a_code_needs_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dac_write_mask == 8'd0) |-> dac_code == 16'd0)
        else $error("dac code without write mask");

    // learn position never passes the end of the map
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(learn_position[4] && learn_position[3:0] != 4'd0))
        else $error("learn position beyond map");

    // a full skid entry blocks the input until the output moves
    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && out_stall) |=> in_stall)
        else $error("skid entry lost while output stalled");

endmodule
